@@ rtl/ffsp_pkg.sv @@
// ----------------------------------------------------------------------------
// ffsp_pkg: shared types and constants for the format descriptor parser
// Character codes, descriptor kinds, error codes, parse phases and the
// structs passed between the parser modules.
// ----------------------------------------------------------------------------
package ffsp_pkg;

	localparam int OUT_W = 16;

	localparam logic [7:0] CH_OPEN     = 8'h28;
	localparam logic [7:0] CH_CLOSE    = 8'h29;
	localparam logic [7:0] CH_DOT      = 8'h2E;
	localparam logic [7:0] CH_EXP      = 8'h45;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_NINE     = 8'h39;
	localparam logic [7:0] CH_LC_A     = 8'h61;
	localparam logic [7:0] CH_LC_Z     = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	localparam int NUM_TYPES = 5;

	// F, I, E, D, G in kind order
	localparam logic [7:0] TYPE_LETTER [0:NUM_TYPES-1] = '{8'h46, 8'h49, 8'h45, 8'h44, 8'h47};

	typedef enum logic [2:0] {
		KIND_F = 3'd0,
		KIND_I = 3'd1,
		KIND_E = 3'd2,
		KIND_D = 3'd3,
		KIND_G = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_NO_OPEN  = 3'd1,
		ERR_NO_CLOSE = 3'd2,
		ERR_BAD_TYPE = 3'd3,
		ERR_NO_WIDTH = 3'd4,
		ERR_BAD_PREC = 3'd5,
		ERR_TRAILING = 3'd6
	} err_t;

	typedef enum logic [10:0] {
		PH_LEAD   = 11'b000_0000_0001,
		PH_COUNT  = 11'b000_0000_0010,
		PH_WSTART = 11'b000_0000_0100,
		PH_WIDTH  = 11'b000_0000_1000,
		PH_PSTART = 11'b000_0001_0000,
		PH_PREC   = 11'b000_0010_0000,
		PH_ESTART = 11'b000_0100_0000,
		PH_EXP    = 11'b000_1000_0000,
		PH_FAIL   = 11'b001_0000_0000,
		PH_NOOPEN = 11'b010_0000_0000,
		PH_DONE   = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic       is_digit;
		logic [3:0] digit;
		logic       is_type;
		kind_t      type_kind;
		logic       is_open;
		logic       is_close;
		logic       is_blank;
		logic       is_dot;
		logic       is_exp;
	} char_class_t;

	typedef struct packed {
		logic             ok;
		err_t             error_kind;
		kind_t            kind;
		logic [OUT_W-1:0] repeat_count;
		logic [OUT_W-1:0] field_width;
		logic [OUT_W-1:0] precision;
		logic [OUT_W-1:0] exponent_digits;
	} result_t;

endpackage

@@ rtl/ffsp_ifs.sv @@
// ----------------------------------------------------------------------------
// ffsp channel interfaces
// Valid/ready channels for format characters and for parse results.
// ----------------------------------------------------------------------------
interface ffsp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

interface ffsp_result_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [2:0]  error_kind;
	logic [2:0]  kind;
	logic [15:0] repeat_count;
	logic [15:0] field_width;
	logic [15:0] precision;
	logic [15:0] exponent_digits;

	modport source (output valid, output ok, output error_kind, output kind,
		output repeat_count, output field_width, output precision,
		output exponent_digits, input ready);
	modport sink (input valid, input ok, input error_kind, input kind,
		input repeat_count, input field_width, input precision,
		input exponent_digits, output ready);
endinterface

@@ rtl/ffsp_char_class.sv @@
// ----------------------------------------------------------------------------
// ffsp_char_class: character classifier
// Decodes one format byte into digit, type letter and punctuation flags.
// ----------------------------------------------------------------------------
module ffsp_char_class (
	input  logic [7:0]          ch,
	output ffsp_pkg::char_class_t cls
);
	import ffsp_pkg::*;

	logic [7:0] upper;

	always_comb begin
		upper = (ch >= CH_LC_A && ch <= CH_LC_Z) ? ch - CASE_OFFSET : ch;

		cls.is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
		cls.digit     = ch[3:0];
		cls.is_open   = (ch == CH_OPEN);
		cls.is_close  = (ch == CH_CLOSE);
		cls.is_blank  = (ch == CH_SPACE) || (ch == CH_TAB);
		cls.is_dot    = (ch == CH_DOT);
		// exponent marker is upper case only
		cls.is_exp    = (ch == CH_EXP);
		cls.is_type   = 1'b0;
		cls.type_kind = KIND_F;
		for (int i = 0; i < NUM_TYPES; i++) begin
			if (upper == TYPE_LETTER[i]) begin
				cls.is_type   = 1'b1;
				cls.type_kind = kind_t'(3'(i));
			end
		end
	end

endmodule

@@ rtl/ffsp_digit_acc.sv @@
// ----------------------------------------------------------------------------
// ffsp_digit_acc: saturating decimal accumulator
// Computes acc * 10 + digit, clamped to the all-ones value.
// ----------------------------------------------------------------------------
module ffsp_digit_acc #(
	parameter int VALUE_BITS = 16
) (
	input  logic [VALUE_BITS-1:0] acc,
	input  logic [3:0]            digit,
	output logic [VALUE_BITS-1:0] sum
);

	logic [VALUE_BITS+3:0] wide;

	always_comb begin
		// times ten as shift-and-add; four guard bits hold any overflow
		wide = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1)
			+ {{VALUE_BITS{1'b0}}, digit};
		sum  = (|wide[VALUE_BITS+3:VALUE_BITS]) ? {VALUE_BITS{1'b1}} : wide[VALUE_BITS-1:0];
	end

endmodule

@@ rtl/ffsp_parser.sv @@
// ----------------------------------------------------------------------------
// ffsp_parser: descriptor phase machine and result register
// Steps the parse state by one character per cycle unless a new result meets an unread
// one, and registers a result at the closing parenthesis or at the end of the string.
// ----------------------------------------------------------------------------
module ffsp_parser #(
	parameter int VALUE_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s1,
	input  logic [7:0]        ch_s1,
	input  logic              last_s1,
	input  logic              out_ready,
	output logic              advance,
	output logic              valid_s2,
	output ffsp_pkg::result_t res_s2
);
	import ffsp_pkg::*;

	localparam int EXT_W = (VALUE_BITS > OUT_W) ? VALUE_BITS : OUT_W;

	char_class_t cls;

	phase_t                phase_q,  phase_d;
	err_t                  ferr_q,   ferr_d;
	kind_t                 kind_q,   kind_d;
	logic [VALUE_BITS-1:0] rep_q,    rep_d;
	logic [VALUE_BITS-1:0] wid_q,    wid_d;
	logic [VALUE_BITS-1:0] prec_q,   prec_d;
	logic [VALUE_BITS-1:0] exp_q,    exp_d;
	logic                  seen_q,   seen_d;

	logic [VALUE_BITS-1:0] acc_in, acc_out;
	logic                  emit;
	err_t                  emit_err;
	logic                  out_free;
	logic [EXT_W-1:0]      rep_x, wid_x, prec_x, exp_x;
	result_t               res_d;

	ffsp_char_class u_class (
		.ch  (ch_s1),
		.cls (cls)
	);

	// one accumulator shared by all fields: only one field grows per beat
	always_comb begin
		case (phase_q) inside
			PH_COUNT:            acc_in = rep_q;
			PH_WSTART, PH_WIDTH: acc_in = wid_q;
			PH_PSTART, PH_PREC:  acc_in = prec_q;
			default:             acc_in = exp_q;
		endcase
	end

	ffsp_digit_acc #(.VALUE_BITS(VALUE_BITS)) u_acc (
		.acc   (acc_in),
		.digit (cls.digit),
		.sum   (acc_out)
	);

	always_comb begin
		phase_d  = phase_q;
		ferr_d   = ferr_q;
		kind_d   = kind_q;
		rep_d    = rep_q;
		wid_d    = wid_q;
		prec_d   = prec_q;
		exp_d    = exp_q;
		seen_d   = seen_q;
		emit     = 1'b0;
		emit_err = ERR_NONE;

		unique case (phase_q)
			PH_LEAD: begin
				if (cls.is_blank) begin
					phase_d = PH_LEAD;
				end else if (cls.is_open) begin
					ferr_d  = ERR_NONE;
					kind_d  = KIND_F;
					rep_d   = '0;
					wid_d   = '0;
					prec_d  = '0;
					exp_d   = '0;
					seen_d  = 1'b0;
					phase_d = PH_COUNT;
				end else begin
					ferr_d  = ERR_NO_OPEN;
					phase_d = PH_NOOPEN;
					if (cls.is_close) begin
						emit     = 1'b1;
						emit_err = ERR_NO_OPEN;
					end
				end
			end
			PH_NOOPEN: begin
				if (cls.is_close) begin
					emit     = 1'b1;
					emit_err = ERR_NO_OPEN;
				end
			end
			PH_COUNT: begin
				if (cls.is_digit) begin
					rep_d  = acc_out;
					seen_d = 1'b1;
				end else if (cls.is_type) begin
					kind_d  = cls.type_kind;
					phase_d = PH_WSTART;
					if (!seen_q) rep_d = VALUE_BITS'(1);
				end else if (cls.is_close) begin
					emit     = 1'b1;
					emit_err = ERR_BAD_TYPE;
				end else begin
					ferr_d  = ERR_BAD_TYPE;
					phase_d = PH_FAIL;
				end
			end
			PH_WSTART: begin
				if (cls.is_digit) begin
					wid_d   = acc_out;
					phase_d = PH_WIDTH;
				end else if (cls.is_close) begin
					emit     = 1'b1;
					emit_err = ERR_NO_WIDTH;
				end else begin
					ferr_d  = ERR_NO_WIDTH;
					phase_d = PH_FAIL;
				end
			end
			PH_WIDTH: begin
				if (cls.is_digit) begin
					wid_d = acc_out;
				end else if (cls.is_dot) begin
					phase_d = PH_PSTART;
				end else if (cls.is_close) begin
					// only I may omit the precision
					emit     = 1'b1;
					emit_err = (kind_q == KIND_I) ? ERR_NONE : ERR_BAD_PREC;
				end else begin
					ferr_d  = (kind_q == KIND_I) ? ERR_TRAILING : ERR_BAD_PREC;
					phase_d = PH_FAIL;
				end
			end
			PH_PSTART: begin
				if (cls.is_digit) begin
					prec_d  = acc_out;
					phase_d = PH_PREC;
				end else if (cls.is_close) begin
					emit     = 1'b1;
					emit_err = ERR_BAD_PREC;
				end else begin
					ferr_d  = ERR_BAD_PREC;
					phase_d = PH_FAIL;
				end
			end
			PH_PREC: begin
				if (cls.is_digit) begin
					prec_d = acc_out;
				end else if (cls.is_close) begin
					emit     = 1'b1;
					emit_err = ERR_NONE;
				end else if (cls.is_exp && kind_q != KIND_F && kind_q != KIND_I) begin
					phase_d = PH_ESTART;
				end else begin
					ferr_d  = ERR_TRAILING;
					phase_d = PH_FAIL;
				end
			end
			PH_ESTART: begin
				if (cls.is_digit) begin
					exp_d   = acc_out;
					phase_d = PH_EXP;
				end else if (cls.is_close) begin
					emit     = 1'b1;
					emit_err = ERR_BAD_PREC;
				end else begin
					ferr_d  = ERR_BAD_PREC;
					phase_d = PH_FAIL;
				end
			end
			PH_EXP: begin
				if (cls.is_digit) begin
					exp_d = acc_out;
				end else if (cls.is_close) begin
					emit     = 1'b1;
					emit_err = ERR_NONE;
				end else begin
					ferr_d  = ERR_TRAILING;
					phase_d = PH_FAIL;
				end
			end
			PH_FAIL: begin
				if (cls.is_close) begin
					emit     = 1'b1;
					emit_err = ferr_q;
				end
			end
			PH_DONE: begin
				phase_d = PH_DONE;
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		if (emit) phase_d = PH_DONE;

		// end of string: report if nothing was given yet, then start afresh
		if (last_s1) begin
			if (!emit && phase_d != PH_DONE) begin
				emit     = 1'b1;
				emit_err = (phase_d == PH_LEAD || phase_d == PH_NOOPEN)
					? ERR_NO_OPEN : ERR_NO_CLOSE;
			end
			phase_d = PH_LEAD;
			ferr_d  = ERR_NONE;
			kind_d  = KIND_F;
			rep_d   = '0;
			wid_d   = '0;
			prec_d  = '0;
			exp_d   = '0;
			seen_d  = 1'b0;
		end
	end

	always_comb begin
		rep_x  = EXT_W'(rep_q);
		wid_x  = EXT_W'(wid_q);
		prec_x = EXT_W'(prec_q);
		exp_x  = EXT_W'(exp_q);

		res_d.ok              = (emit_err == ERR_NONE);
		res_d.error_kind      = emit_err;
		res_d.kind            = res_d.ok ? kind_q : KIND_F;
		res_d.repeat_count    = res_d.ok ? rep_x[OUT_W-1:0]  : '0;
		res_d.field_width     = res_d.ok ? wid_x[OUT_W-1:0]  : '0;
		res_d.precision       = res_d.ok ? prec_x[OUT_W-1:0] : '0;
		res_d.exponent_digits = res_d.ok ? exp_x[OUT_W-1:0]  : '0;
	end

	assign out_free = !valid_s2 || out_ready;
	assign advance  = valid_s1 && (!emit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			ferr_q  <= ERR_NONE;
			kind_q  <= KIND_F;
			rep_q   <= '0;
			wid_q   <= '0;
			prec_q  <= '0;
			exp_q   <= '0;
			seen_q  <= 1'b0;
		end else if (advance) begin
			phase_q <= phase_d;
			ferr_q  <= ferr_d;
			kind_q  <= kind_d;
			rep_q   <= rep_d;
			wid_q   <= wid_d;
			prec_q  <= prec_d;
			exp_q   <= exp_d;
			seen_q  <= seen_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && emit) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) res_s2 <= res_d;
	end

endmodule

@@ rtl/fortran_format_spec_parser.sv @@
// ----------------------------------------------------------------------------
// fortran_format_spec_parser: streaming edit descriptor parser
// Parses one "(count letter width.digits Edigits)" descriptor per string.
// ----------------------------------------------------------------------------
// One format character is taken per beat: it sits in an input register,
// then the phase machine and one shared times-ten accumulator consume it.
// A result enters the result register when the closing parenthesis is
// consumed, or with the last character when no parenthesis closed the
// descriptor; it can wait there while further characters are still
// taken. Characters stall only when a new result is due and the previous
// one has not been taken.
// Fields saturate at 2**VALUE_BITS - 1 and are given as their low 16 bits.
module fortran_format_spec_parser #(
	parameter int VALUE_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	ffsp_char_if.sink       chars,
	ffsp_result_if.source   result
);
	import ffsp_pkg::*;

	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       last_s1;
	logic       advance;
	logic       valid_s2;
	result_t    res_s2;

	assign chars.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.valid && chars.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	ffsp_parser #(.VALUE_BITS(VALUE_BITS)) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ch_s1     (ch_s1),
		.last_s1   (last_s1),
		.out_ready (result.ready),
		.advance   (advance),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2)
	);

	assign result.valid           = valid_s2;
	assign result.ok              = res_s2.ok;
	assign result.error_kind      = res_s2.error_kind;
	assign result.kind            = res_s2.kind;
	assign result.repeat_count    = res_s2.repeat_count;
	assign result.field_width     = res_s2.field_width;
	assign result.precision       = res_s2.precision;
	assign result.exponent_digits = res_s2.exponent_digits;

endmodule

@@ rtl/ffsp_checker.sv @@
// ----------------------------------------------------------------------------
// ffsp_checker: port-level checks for the descriptor parser
// Watches the result channel and checks handshake and field consistency.
// ----------------------------------------------------------------------------
module ffsp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic        ok,
	input logic [2:0]  error_kind,
	input logic [2:0]  kind,
	input logic [15:0] repeat_count,
	input logic [15:0] field_width,
	input logic [15:0] precision,
	input logic [15:0] exponent_digits
);
	import ffsp_pkg::*;

	// a stalled result beat holds its payload
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(error_kind)
			&& $stable(kind) && $stable(repeat_count) && $stable(field_width)
			&& $stable(precision) && $stable(exponent_digits))
		else $error("result payload changed while stalled");

	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (ok == (error_kind == ERR_NONE)))
		else $error("ok flag disagrees with error code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> kind == KIND_F && repeat_count == '0 && field_width == '0
			&& precision == '0 && exponent_digits == '0)
		else $error("failed descriptor carries non-zero fields");

	a_codes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error_kind <= ERR_TRAILING && kind <= KIND_G)
		else $error("result code out of range");

endmodule

bind fortran_format_spec_parser ffsp_checker u_ffsp_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.ok              (result.ok),
	.error_kind      (result.error_kind),
	.kind            (result.kind),
	.repeat_count    (result.repeat_count),
	.field_width     (result.field_width),
	.precision       (result.precision),
	.exponent_digits (result.exponent_digits)
);

@@ tb/fortran_format_spec_parser_test.sv @@
// ----------------------------------------------------------------------------
// fortran_format_spec_parser_test: self-checking bench for the descriptor parser
// Streams format strings one character per beat, predicts each parse result
// in-bench and compares every result beat field by field. Covers valid
// descriptors, every error kind, saturation, random and corrupted strings,
// random pacing on both channels and a long result stall.
// ----------------------------------------------------------------------------
module fortran_format_spec_parser_test;
	import ffsp_pkg::*;

	localparam int VALUE_BITS = 16;
	localparam longint unsigned FIELD_MAX = (64'd1 << VALUE_BITS) - 1;

	logic clk = 1'b0;
	logic arst_n;

	ffsp_char_if   char_bus ();
	ffsp_result_if result_bus ();

	fortran_format_spec_parser #(.VALUE_BITS(VALUE_BITS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_bus),
		.result (result_bus)
	);

	always #5 clk = ~clk;

	// parser state as the bench sees it
	phase_t          ph;
	err_t            first_err;
	kind_t           kind_acc;
	longint unsigned rep_acc, wid_acc, prec_acc, exp_acc;
	bit              digit_seen;

	result_t     pending_results [$];
	logic [7:0]  line_buf [$];
	bit          pace;
	int          hold_off;
	int          fail_count;
	int          chars_sent;
	int          strings_sent;
	int          results_checked;

	function automatic longint unsigned acc_digit(longint unsigned acc, logic [7:0] c);
		longint unsigned v;
		v = acc * 10 + longint'(c - CH_ZERO);
		return (v > FIELD_MAX) ? FIELD_MAX : v;
	endfunction

	function automatic int letter_kind(logic [7:0] c);
		logic [7:0] u;
		u = (c >= CH_LC_A && c <= CH_LC_Z) ? c - CASE_OFFSET : c;
		for (int i = 0; i < NUM_TYPES; i++)
			if (u == TYPE_LETTER[i])
				return i;
		return -1;
	endfunction

	function automatic void clear_parse();
		first_err  = ERR_NONE;
		kind_acc   = KIND_F;
		rep_acc    = 0;
		wid_acc    = 0;
		prec_acc   = 0;
		exp_acc    = 0;
		digit_seen = 1'b0;
	endfunction

	function automatic bit report_descriptor(err_t e, output result_t r);
		bit good;
		good              = (e == ERR_NONE);
		r.ok              = good;
		r.error_kind      = e;
		r.kind            = good ? kind_acc : KIND_F;
		r.repeat_count    = good ? rep_acc[15:0] : 16'd0;
		r.field_width     = good ? wid_acc[15:0] : 16'd0;
		r.precision       = good ? prec_acc[15:0] : 16'd0;
		r.exponent_digits = good ? exp_acc[15:0] : 16'd0;
		ph = PH_DONE;
		return 1'b1;
	endfunction

	function automatic void flag_error(err_t e);
		first_err = e;
		ph = PH_FAIL;
	endfunction

	// one character in, at most one descriptor result out
	function automatic bit parse_char(logic [7:0] c, logic l, output result_t r);
		bit got;
		bit close;
		bit dig;
		int t;
		got   = 1'b0;
		close = (c == CH_CLOSE);
		dig   = (c >= CH_ZERO && c <= CH_NINE);
		t     = letter_kind(c);
		r     = '0;
		case (ph)
			PH_LEAD: begin
				if (c == CH_OPEN) begin
					clear_parse();
					ph = PH_COUNT;
				end else if (c != CH_SPACE && c != CH_TAB) begin
					first_err = ERR_NO_OPEN;
					ph = PH_NOOPEN;
					if (close)
						got = report_descriptor(ERR_NO_OPEN, r);
				end
			end
			PH_NOOPEN: begin
				if (close)
					got = report_descriptor(ERR_NO_OPEN, r);
			end
			PH_COUNT: begin
				if (dig) begin
					rep_acc = acc_digit(rep_acc, c);
					digit_seen = 1'b1;
				end else if (t >= 0) begin
					kind_acc = kind_t'(t[2:0]);
					if (!digit_seen)
						rep_acc = 1;
					ph = PH_WSTART;
				end else if (close)
					got = report_descriptor(ERR_BAD_TYPE, r);
				else
					flag_error(ERR_BAD_TYPE);
			end
			PH_WSTART: begin
				if (dig) begin
					wid_acc = acc_digit(wid_acc, c);
					ph = PH_WIDTH;
				end else if (close)
					got = report_descriptor(ERR_NO_WIDTH, r);
				else
					flag_error(ERR_NO_WIDTH);
			end
			PH_WIDTH: begin
				if (dig)
					wid_acc = acc_digit(wid_acc, c);
				else if (c == CH_DOT)
					ph = PH_PSTART;
				else if (close)
					got = report_descriptor((kind_acc == KIND_I) ? ERR_NONE : ERR_BAD_PREC, r);
				else
					flag_error((kind_acc == KIND_I) ? ERR_TRAILING : ERR_BAD_PREC);
			end
			PH_PSTART: begin
				if (dig) begin
					prec_acc = acc_digit(prec_acc, c);
					ph = PH_PREC;
				end else if (close)
					got = report_descriptor(ERR_BAD_PREC, r);
				else
					flag_error(ERR_BAD_PREC);
			end
			PH_PREC: begin
				if (dig)
					prec_acc = acc_digit(prec_acc, c);
				else if (close)
					got = report_descriptor(ERR_NONE, r);
				else if (c == CH_EXP && kind_acc != KIND_F && kind_acc != KIND_I)
					ph = PH_ESTART;
				else
					flag_error(ERR_TRAILING);
			end
			PH_ESTART: begin
				if (dig) begin
					exp_acc = acc_digit(exp_acc, c);
					ph = PH_EXP;
				end else if (close)
					got = report_descriptor(ERR_BAD_PREC, r);
				else
					flag_error(ERR_BAD_PREC);
			end
			PH_EXP: begin
				if (dig)
					exp_acc = acc_digit(exp_acc, c);
				else if (close)
					got = report_descriptor(ERR_NONE, r);
				else
					flag_error(ERR_TRAILING);
			end
			PH_FAIL: begin
				if (close)
					got = report_descriptor(first_err, r);
			end
			default: ;
		endcase
		if (l) begin
			// string ends: a missing ')' outranks any earlier error but a missing '('
			if (!got && ph != PH_DONE)
				got = report_descriptor((ph == PH_LEAD || ph == PH_NOOPEN) ?
					ERR_NO_OPEN : ERR_NO_CLOSE, r);
			ph = PH_LEAD;
			clear_parse();
		end
		return got;
	endfunction

	task automatic send_char(input logic [7:0] c, input logic l);
		int gap;
		result_t r;
		gap = pace ? $urandom_range(0, 18) : 0;
		// valid only drops when there is a gap, so no double assignment per step
		if (gap > 0) begin
			char_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_bus.valid <= 1'b1;
		char_bus.ch    <= c;
		char_bus.last  <= l;
		do @(posedge clk); while (!char_bus.ready);
		if (parse_char(c, l, r))
			pending_results.push_back(r);
		chars_sent++;
	endtask

	task automatic send_line();
		for (int i = 0; i < line_buf.size(); i++)
			send_char(line_buf[i], i == line_buf.size() - 1);
		strings_sent++;
	endtask

	task automatic send_text(input string s);
		line_buf.delete();
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
		send_line();
	endtask

	function automatic int digit_run(int none_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < none_pct)
			return 0;
		if (r >= 95)
			return 6;	// long enough to saturate
		return $urandom_range(1, 3);
	endfunction

	task automatic push_digits(input int n);
		repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	// mostly well-formed descriptor with random content, some corrupted
	task automatic build_descriptor();
		int k;
		int pos;
		logic [7:0] letter;
		line_buf.delete();
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(1, 255)));
			return;
		end
		repeat ($urandom_range(0, 3))
			line_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
		line_buf.push_back(CH_OPEN);
		push_digits(digit_run(50));
		k = $urandom_range(0, NUM_TYPES - 1);
		letter = TYPE_LETTER[k];
		line_buf.push_back($urandom_range(0, 1) ? letter + CASE_OFFSET : letter);
		push_digits(digit_run(4));
		if (k != KIND_I || $urandom_range(0, 1)) begin
			line_buf.push_back(CH_DOT);
			push_digits(digit_run(4));
		end
		if (k >= KIND_E && $urandom_range(0, 1)) begin
			line_buf.push_back(CH_EXP);
			push_digits(digit_run(4));
		end
		line_buf.push_back(CH_CLOSE);
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) line_buf.push_back(8'($urandom_range(1, 255)));
		if ($urandom_range(0, 99) < 22) begin
			pos = $urandom_range(0, line_buf.size() - 1);
			case ($urandom_range(0, 3))
				0: line_buf[pos] = 8'($urandom_range(1, 255));
				1: line_buf[pos] = $urandom_range(0, 1) ? CH_DOT : 8'h65;	// '.' or 'e'
				2: if (line_buf.size() > 1) line_buf.delete(pos);
				default: while (line_buf.size() > pos + 1) line_buf.pop_back();
			endcase
		end
	endtask

	task automatic test_valid_descriptors();
		send_text("(F8.3)");
		send_text("(i5)");
		send_text("(I5.3)");
		send_text("(3E12.4E2)");
		send_text("(2d10.3)");
		send_text("(g0.0E0)");
		send_text(" \t (f1.0)");
		send_text("(F8.3)tail");
	endtask

	task automatic test_malformed_descriptors();
		send_text("F8.3)");
		send_text(")");
		send_text(" \t ");
		send_text("(F8.3");
		send_text("(F8.3x");
		send_text("(X5)");
		send_text("()");
		send_text("(\377)");
		send_text("(F.3)");
		send_text("(F8)");
		send_text("(F8.)");
		send_text("(E8.3E)");
		send_text("(I5 )");
		send_text("(E8.3e2)");
		send_text("(F8.3E2)");
	endtask

	task automatic test_field_saturation();
		send_text("(99999999F99999999.99999999E99999999)");
		send_text("(65535G65535.65535E65535)");
	endtask

	task automatic test_random_strings();
		int start;
		start = chars_sent;
		while (chars_sent - start < 550) begin
			if (strings_sent % 40 == 0)
				pace = ($urandom_range(0, 3) != 0);
			build_descriptor();
			send_line();
		end
		pace = 1'b1;
	endtask

	task automatic test_result_backpressure();
		pace = 1'b0;
		hold_off = 300;
		repeat (25) begin
			build_descriptor();
			send_line();
		end
		pace = 1'b1;
	endtask

	// result sink: random stall before each beat while paced, long hold on request
	initial begin
		int n;
		result_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off > 0) begin
				n = hold_off;
				hold_off = 0;
			end else
				n = pace ? $urandom_range(0, 18) : 0;
			if (n > 0) begin
				result_bus.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_bus.ready <= 1'b1;
			do @(posedge clk); while (result_bus.valid !== 1'b1);
		end
	end

	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("result beat with no descriptor pending");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("ok", 16'(want.ok), 16'(result_bus.ok));
				check_field("error_kind", 16'(want.error_kind), 16'(result_bus.error_kind));
				check_field("kind", 16'(want.kind), 16'(result_bus.kind));
				check_field("repeat_count", want.repeat_count, result_bus.repeat_count);
				check_field("field_width", want.field_width, result_bus.field_width);
				check_field("precision", want.precision, result_bus.precision);
				check_field("exponent_digits", want.exponent_digits, result_bus.exponent_digits);
				results_checked++;
			end
		end
	end

	initial begin
		#6000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n         = 1'b0;
		char_bus.valid = 1'b0;
		char_bus.ch    = CH_SPACE;
		char_bus.last  = 1'b0;
		pace           = 1'b1;
		hold_off       = 0;
		ph             = PH_LEAD;
		clear_parse();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_valid_descriptors();
		test_malformed_descriptors();
		test_field_saturation();
		test_random_strings();
		test_result_backpressure();

		char_bus.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d characters in %0d format strings, checked %0d descriptor results.",
			chars_sent, strings_sent, results_checked);
		$display("Directed, saturating and corrupted strings, paced and back-to-back, with a long result stall.");
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
